### sv/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the multi-pin debouncer: pin count, phase
// encoding, register indexes and the event bundle passed between stages.
// ----------------------------------------------------------------------------
package mpd_pkg;

	// pin count and derived widths
	localparam int NUM_PINS   = 5;
	localparam int PIN_IDX_W  = 3;
	localparam int TICKS_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// reset values of the registers
	localparam logic [TICKS_W-1:0]  TICKS_RESET  = 8'd10;
	localparam logic [NUM_PINS-1:0] ENABLE_RESET = 5'd31;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd1;

	// per-pin phase
	typedef enum logic [1:0] {
		PH_LOW  = 2'd0,
		PH_RISE = 2'd1,
		PH_HIGH = 2'd2,
		PH_FALL = 2'd3
	} phase_t;

	// change events caused by one accepted sample
	typedef struct packed {
		logic [NUM_PINS-1:0] mask;  // pins that emit an event
		logic [NUM_PINS-1:0] lvl;   // committed level of each emitting pin
		logic [NUM_PINS-1:0] filt;  // reported levels after the whole sample
	} ev_t;

endpackage

### sv/mpd_pin_bank.sv
// ----------------------------------------------------------------------------
// mpd_pin_bank
// Per-pin debounce state machines and countdowns, plus the configuration
// registers. Updates every pin in the cycle a sample is taken and reports
// the resulting change events.
// ----------------------------------------------------------------------------
module mpd_pin_bank (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           sample_we,
	input  logic [mpd_pkg::NUM_PINS-1:0]   pin_levels,
	input  logic                           tick,
	output mpd_pkg::ev_t                   ev
);

	logic [mpd_pkg::TICKS_W-1:0]  ticks_q;
	logic [mpd_pkg::NUM_PINS-1:0] enable_q;
	logic                         started_q;
	mpd_pkg::phase_t              phase_q [mpd_pkg::NUM_PINS];
	logic [mpd_pkg::TICKS_W-1:0]  count_q [mpd_pkg::NUM_PINS];

	mpd_pkg::phase_t              phase_d [mpd_pkg::NUM_PINS];
	logic [mpd_pkg::TICKS_W-1:0]  count_d [mpd_pkg::NUM_PINS];
	logic [mpd_pkg::TICKS_W-1:0]  start_cnt;

	// a tick count of zero behaves as one
	assign start_cnt = (ticks_q == '0) ? mpd_pkg::TICKS_W'(1) : ticks_q;

	// next phase, countdown and event of every pin for the sample at the input
	always_comb begin
		mpd_pkg::phase_t             ph;
		logic [mpd_pkg::TICKS_W-1:0] cnt;
		logic                        emit;
		logic                        elvl;
		logic                        pv;
		ev.mask = '0;
		ev.lvl  = '0;
		ev.filt = '0;
		for (int i = 0; i < mpd_pkg::NUM_PINS; i++) begin
			pv   = pin_levels[i];
			ph   = phase_q[i];
			cnt  = count_q[i];
			emit = 1'b0;
			elvl = 1'b0;
			if (!started_q) begin
				ph  = pv ? mpd_pkg::PH_HIGH : mpd_pkg::PH_LOW;
				cnt = '0;
			end else begin
				// tick first, on countdowns already running
				if (tick && cnt != '0) begin
					cnt = cnt - mpd_pkg::TICKS_W'(1);
					if (cnt == '0) begin
						if (ph == mpd_pkg::PH_RISE) begin
							ph   = mpd_pkg::PH_HIGH;
							emit = 1'b1;
							elvl = 1'b1;
						end else if (ph == mpd_pkg::PH_FALL) begin
							ph   = mpd_pkg::PH_LOW;
							emit = 1'b1;
							elvl = 1'b0;
						end
					end
				end
				// then the sample
				if (enable_q[i]) begin
					if (ph == mpd_pkg::PH_LOW && pv) begin
						ph  = mpd_pkg::PH_RISE;
						cnt = start_cnt;
					end else if (ph == mpd_pkg::PH_RISE && !pv) begin
						ph  = mpd_pkg::PH_LOW;
						cnt = '0;
					end else if (ph == mpd_pkg::PH_HIGH && !pv) begin
						ph  = mpd_pkg::PH_FALL;
						cnt = start_cnt;
					end else if (ph == mpd_pkg::PH_FALL && pv) begin
						ph  = mpd_pkg::PH_HIGH;
						cnt = '0;
					end
				end else if (!emit) begin
					if (ph == mpd_pkg::PH_LOW && pv) begin
						ph   = mpd_pkg::PH_HIGH;
						emit = 1'b1;
						elvl = 1'b1;
					end else if (ph == mpd_pkg::PH_HIGH && !pv) begin
						ph   = mpd_pkg::PH_LOW;
						emit = 1'b1;
						elvl = 1'b0;
					end
				end
			end
			phase_d[i]  = ph;
			count_d[i]  = cnt;
			ev.mask[i]  = emit;
			ev.lvl[i]   = elvl;
			ev.filt[i]  = (ph == mpd_pkg::PH_HIGH) || (ph == mpd_pkg::PH_FALL);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= mpd_pkg::TICKS_RESET;
			enable_q <= mpd_pkg::ENABLE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpd_pkg::CFG_TICKS:  ticks_q  <= cfg_data[mpd_pkg::TICKS_W-1:0];
				mpd_pkg::CFG_ENABLE: enable_q <= cfg_data[mpd_pkg::NUM_PINS-1:0];
				default: ;
			endcase
		end
	end

	// first-sample flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (sample_we && !cfg_we) begin
			started_q <= 1'b1;
		end
	end

	// pin state; writing the enable mask settles pending pins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mpd_pkg::NUM_PINS; i++) begin
				phase_q[i] <= mpd_pkg::PH_LOW;
				count_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == mpd_pkg::CFG_ENABLE) begin
				for (int i = 0; i < mpd_pkg::NUM_PINS; i++) begin
					count_q[i] <= '0;
					if (phase_q[i] == mpd_pkg::PH_RISE) begin
						phase_q[i] <= mpd_pkg::PH_HIGH;
					end else if (phase_q[i] == mpd_pkg::PH_FALL) begin
						phase_q[i] <= mpd_pkg::PH_LOW;
					end
				end
			end
		end else if (sample_we) begin
			for (int i = 0; i < mpd_pkg::NUM_PINS; i++) begin
				phase_q[i] <= phase_d[i];
				count_q[i] <= count_d[i];
			end
		end
	end

endmodule

### sv/mpd_event_out.sv
// ----------------------------------------------------------------------------
// mpd_event_out
// Holds the events of one sample and hands them out one beat per cycle while
// the receiver is ready, lowest pin first, through a registered output stage.
// ----------------------------------------------------------------------------
module mpd_event_out (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  mpd_pkg::ev_t                        ev_in,
	output logic                                load_ok,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mpd_pkg::PIN_IDX_W-1:0]       pin_index,
	output logic                                new_level,
	output logic [mpd_pkg::NUM_PINS-1:0]        filtered_levels,
	output logic                                last
);

	logic [mpd_pkg::NUM_PINS-1:0]  pend_mask_q;
	logic [mpd_pkg::NUM_PINS-1:0]  pend_lvl_q;
	logic [mpd_pkg::NUM_PINS-1:0]  pend_filt_q;
	logic                          out_valid_q;
	logic [mpd_pkg::PIN_IDX_W-1:0] out_pin_q;
	logic                          out_lvl_q;
	logic [mpd_pkg::NUM_PINS-1:0]  out_filt_q;
	logic                          out_last_q;

	logic                          adv;
	logic [mpd_pkg::PIN_IDX_W-1:0] sel;
	logic [mpd_pkg::NUM_PINS-1:0]  sel_oh;
	logic [mpd_pkg::NUM_PINS-1:0]  rest;
	logic [mpd_pkg::NUM_PINS-1:0]  pend_after;

	// output register free to take the next beat
	assign adv = !out_valid_q || out_ready;

	// lowest pending pin
	always_comb begin
		sel    = '0;
		sel_oh = '0;
		for (int i = mpd_pkg::NUM_PINS - 1; i >= 0; i--) begin
			if (pend_mask_q[i]) begin
				sel    = mpd_pkg::PIN_IDX_W'(i);
				sel_oh = mpd_pkg::NUM_PINS'(1) << i;
			end
		end
	end

	assign rest       = pend_mask_q & ~sel_oh;
	assign pend_after = adv ? rest : pend_mask_q;
	assign load_ok    = (pend_after == '0);

	// pending events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
		end else if (load) begin
			pend_mask_q <= ev_in.mask;
		end else begin
			pend_mask_q <= pend_after;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pend_lvl_q  <= ev_in.lvl;
			pend_filt_q <= ev_in.filt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= (pend_mask_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pend_mask_q != '0) begin
			out_pin_q  <= sel;
			out_lvl_q  <= pend_lvl_q[sel];
			out_filt_q <= pend_filt_q;
			out_last_q <= (rest == '0);
		end
	end

	assign out_valid       = out_valid_q;
	assign pin_index       = out_pin_q;
	assign new_level       = out_lvl_q;
	assign filtered_levels = out_filt_q;
	assign last            = out_last_q;

endmodule

### sv/multi_pin_debouncer.sv
// ----------------------------------------------------------------------------
// multi_pin_debouncer
// Debounces five switch pins sampled together and reports committed changes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat carries pin_levels and tick.
// The first beat after reset only loads each pin from its level.
// Output channel (out_valid/out_ready): one beat per committed change, lowest
// pin first, with filtered_levels after the whole sample and last on the
// final event of that sample.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the tick
// count, index 1 the enable mask; writing the mask settles pending pins.
// A sample is refused in any cycle in which a register write is offered.
// Events of a sample pass through the pending-event register, then the output register.
// Throughput: a sample is taken every cycle while no events are queued; a
// sample with events holds the input until its last event moves into the
// single output register, one event per cycle while the receiver is ready.
// Reset: all pins stable low, no countdowns, tick count 10, all enabled.
// When the receiver stalls, the output beat holds and queued events wait;
// the input is refused until the queue can drain into the output register.
// ----------------------------------------------------------------------------
module multi_pin_debouncer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mpd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mpd_pkg::NUM_PINS-1:0]        pin_levels,
	input  logic                                tick,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mpd_pkg::PIN_IDX_W-1:0]       pin_index,
	output logic                                new_level,
	output logic [mpd_pkg::NUM_PINS-1:0]        filtered_levels,
	output logic                                last
);

	mpd_pkg::ev_t ev;
	logic         cfg_we;
	logic         sample_we;
	logic         load_ok;

	// handshakes; a register write takes the cycle, samples wait
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_ready  = load_ok && !cfg_valid;
	assign sample_we = in_valid && in_ready;

	mpd_pin_bank u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample_we  (sample_we),
		.pin_levels (pin_levels),
		.tick       (tick),
		.ev         (ev)
	);

	mpd_event_out u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (sample_we && !cfg_we),
		.ev_in           (ev),
		.load_ok         (load_ok),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pin_index       (pin_index),
		.new_level       (new_level),
		.filtered_levels (filtered_levels),
		.last            (last)
	);

endmodule
